@@ hdl/hct_pkg.sv @@
// Shared types, constants and sine table functions for the harmonic tone canceller.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package hct_pkg;

    // Default values of the top level parameters
    localparam int MAX_HARMONICS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // Fixed datapath widths
    localparam int GAIN_BITS      = 32;   // Q9.23 gains
    localparam int REF_BITS       = 16;   // Q1.15 references
    localparam int REF_FRAC       = 15;
    localparam int STEP_FRAC      = 24;   // Q0.24 step
    localparam int PHASE_BITS     = 32;
    localparam int COUNT_REG_BITS = 4;
    localparam int PHASE_INC_BITS = 31;
    localparam int STEP_BITS      = 24;

    // APB register map
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;
    localparam int REG_IDX_BITS  = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_ACTIVE = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PHASE  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP   = 2'd2;

    localparam logic [COUNT_REG_BITS-1:0] ACTIVE_RESET = 4'd1;
    localparam logic [PHASE_INC_BITS-1:0] PHASE_RESET  = 31'd4473924;
    localparam logic [STEP_BITS-1:0]      STEP_RESET   = 24'd10978;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Configuration seen by every cell
    typedef struct packed {
        logic [PHASE_INC_BITS-1:0] phase_increment;
        logic [STEP_BITS-1:0]      step_base;
    } hct_cfg_t;

    // Two Q30 multiplications of the Taylor series
    function automatic longint unsigned series_step(input longint unsigned t,
                                                    input longint unsigned x);
        longint unsigned p;
        p = (t * x) >> 30;
        p = (p * x) >> 30;
        return p;
    endfunction

    // 32767 * sin(pi/2 * j / quarter), Q30 series, rounded half up, capped
    function automatic logic [15:0] quarter_sine(input int unsigned j,
                                                 input int unsigned abits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (64'(j) * HALF_PI_Q30) >> (abits - 2);
        term = x;
        sum  = x;
        term = series_step(term, x) / 64'd6;   sum = sum - term;
        term = series_step(term, x) / 64'd20;  sum = sum + term;
        term = series_step(term, x) / 64'd42;  sum = sum - term;
        term = series_step(term, x) / 64'd72;  sum = sum + term;
        term = series_step(term, x) / 64'd110; sum = sum - term;
        term = series_step(term, x) / 64'd156; sum = sum + term;
        term = series_step(term, x) / 64'd210; sum = sum - term;
        term = series_step(term, x) / 64'd272; sum = sum + term;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return 16'(v);
    endfunction

    // Full-circle table entry built from the quarter wave
    function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                      input int unsigned abits);
        int unsigned quarter;
        int unsigned quad;
        int unsigned r;
        logic [15:0] v;
        quarter = 32'd1 << (abits - 2);
        quad    = i >> (abits - 2);
        r       = i & (quarter - 32'd1);
        v       = quad[0] ? quarter_sine(quarter - r, abits) : quarter_sine(r, abits);
        return quad[1] ? signed'(16'd0 - v) : signed'(v);
    endfunction

endpackage

@@ hdl/hct_sine_rom.sv @@
// Constant Q1.15 sine table with a registered read port.
// Depends on hct_pkg for the table entry function.
`timescale 1ns / 1ps

module hct_sine_rom #(
    parameter int ADDR_BITS = hct_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic [ADDR_BITS-1:0]                addr,
    output logic signed [hct_pkg::REF_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    typedef logic signed [hct_pkg::REF_BITS-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < DEPTH; i++)
        begin
            t[i] = hct_pkg::sine_entry(i, ADDR_BITS);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [hct_pkg::REF_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= ROM[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hct_cell.sv @@
// One canceller cell: oscillator, quadrature gains and LMS update of one harmonic.
// Depends on hct_pkg and hct_sine_rom.
`timescale 1ns / 1ps

module hct_cell #(
    parameter int SAMPLE_BITS     = hct_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = hct_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_HARMONICS   = hct_pkg::MAX_HARMONICS_DEF,
    parameter int HARM_NUM        = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hct_pkg::hct_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int GB        = hct_pkg::GAIN_BITS;
    localparam int RB        = hct_pkg::REF_BITS;
    localparam int PROD_BITS = GB + RB;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int RND_BITS  = SUM_BITS + 1;
    localparam int EST_BITS  = RND_BITS - hct_pkg::REF_FRAC;
    localparam int DIFF_BITS = ((SAMPLE_BITS > EST_BITS) ? SAMPLE_BITS : EST_BITS) + 1;
    localparam int RC_BITS   = SAMPLE_BITS + RB + 1;
    localparam int TERM_BITS = SAMPLE_BITS + 1;
    localparam int MU_BITS   = hct_pkg::STEP_BITS + $clog2(MAX_HARMONICS + 1);
    localparam int TM_BITS   = TERM_BITS + MU_BITS + 2;
    localparam int CORR_BITS = TM_BITS - hct_pkg::STEP_FRAC;
    localparam int UPD_BITS  = ((CORR_BITS > GB) ? CORR_BITS : GB) + 1;

    localparam logic signed [RND_BITS-1:0]  EST_HALF = RND_BITS'(64'sd1 <<< 14);
    localparam logic signed [RC_BITS-1:0]   RC_HALF  = RC_BITS'(64'sd1 <<< 14);
    localparam logic signed [TM_BITS-1:0]   TM_HALF  = TM_BITS'(64'sd1 <<< 23);
    localparam logic signed [DIFF_BITS-1:0] R_HI =
        DIFF_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [DIFF_BITS-1:0] R_LO =
        DIFF_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [UPD_BITS-1:0]  G_HI = UPD_BITS'(64'sd2147483647);
    localparam logic signed [UPD_BITS-1:0]  G_LO = UPD_BITS'(-64'sd2147483648);
    localparam logic [TABLE_ADDR_BITS-1:0]  QTR_OFFSET =
        TABLE_ADDR_BITS'(1 << (TABLE_ADDR_BITS - 2));

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RDCOS = 9'b000000010,
        ST_PCOS  = 9'b000000100,
        ST_PEST  = 9'b000001000,
        ST_RESID = 9'b000010000,
        ST_ERRC  = 9'b000100000,
        ST_ERRS  = 9'b001000000,
        ST_UPDC  = 9'b010000000,
        ST_UPDS  = 9'b100000000
    } cell_state_t;

    cell_state_t state_reg, state_next;
    logic pending_reg, pending_next;
    logic [hct_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic signed [GB-1:0] cw_reg, cw_next;
    logic signed [GB-1:0] sw_reg, sw_next;
    logic signed [SAMPLE_BITS-1:0] rin_reg, rin_next;
    logic signed [SAMPLE_BITS-1:0] r_reg, r_next;
    logic signed [RB-1:0] s_reg, s_next;
    logic signed [RB-1:0] c_reg, c_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [TERM_BITS-1:0] t_reg, t_next;
    logic signed [CORR_BITS-1:0] e_reg, e_next;
    logic [hct_pkg::PHASE_BITS-1:0] inc_reg, inc_next;
    logic [MU_BITS-1:0] mu_reg, mu_next;

    logic signed [RB-1:0] rom_q;
    logic [TABLE_ADDR_BITS-1:0] sin_idx, rom_addr;
    logic signed [PROD_BITS-1:0] cprod, sprod;
    logic signed [RND_BITS-1:0] sum_round;
    logic signed [EST_BITS-1:0] est;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SAMPLE_BITS-1:0] r_sat;
    logic signed [RB-1:0] ref_sel;
    logic signed [RC_BITS-1:0] rc_prod, rc_round;
    logic signed [MU_BITS:0] mu_s;
    logic signed [TM_BITS-1:0] tm_prod, tm_round;
    logic signed [GB-1:0] g_sel;
    logic signed [UPD_BITS-1:0] g_sum;
    logic signed [GB-1:0] g_sat;

    // sine read at accept, cosine on the following cycle
    assign sin_idx  = phase_reg[hct_pkg::PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign rom_addr = (state_reg == ST_IDLE) ? sin_idx : sin_idx + QTR_OFFSET;

    hct_sine_rom #(
        .ADDR_BITS(TABLE_ADDR_BITS)
    ) u_rom (
        .clk   (clk),
        .addr  (rom_addr),
        .rdata (rom_q)
    );

    // estimate and residual
    assign cprod     = cw_reg * rom_q;
    assign sprod     = sw_reg * s_reg;
    assign sum_round = RND_BITS'(sum_reg) + EST_HALF;
    assign est       = EST_BITS'(sum_round >>> hct_pkg::REF_FRAC);
    assign diff      = DIFF_BITS'(rin_reg) - DIFF_BITS'(est);
    assign r_sat     = (diff > R_HI) ? SAMPLE_BITS'(R_HI) :
                       (diff < R_LO) ? SAMPLE_BITS'(R_LO) : SAMPLE_BITS'(diff);

    // error terms
    assign ref_sel  = (state_reg == ST_ERRC) ? c_reg : s_reg;
    assign rc_prod  = r_reg * ref_sel;
    assign rc_round = rc_prod + RC_HALF;
    assign mu_s     = {1'b0, mu_reg};
    assign tm_prod  = t_reg * mu_s;
    assign tm_round = tm_prod + TM_HALF;

    // gain update
    assign g_sel = (state_reg == ST_UPDC) ? cw_reg : sw_reg;
    assign g_sum = UPD_BITS'(g_sel) + UPD_BITS'(e_reg);
    assign g_sat = (g_sum > G_HI) ? GB'(G_HI) :
                   (g_sum < G_LO) ? GB'(G_LO) : GB'(g_sum);

    assign mu_next  = MU_BITS'(cfg.step_base * MU_BITS'(HARM_NUM));
    assign inc_next = hct_pkg::PHASE_BITS'(cfg.phase_increment *
                                           hct_pkg::PHASE_BITS'(HARM_NUM));

    assign in_ready   = (state_reg == ST_IDLE) && !pending_reg;
    assign out_valid  = pending_reg;
    assign out_sample = r_reg;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        cw_next      = cw_reg;
        sw_next      = sw_reg;
        rin_next     = rin_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        t_next       = t_reg;
        e_next       = e_reg;

        if (pending_reg && out_ready)
        begin
            pending_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !pending_reg)
                begin
                    rin_next   = in_sample;
                    state_next = ST_RDCOS;
                end
            end
            ST_RDCOS:
            begin
                s_next     = rom_q;
                state_next = ST_PCOS;
            end
            ST_PCOS:
            begin
                c_next     = rom_q;
                prod_next  = cprod;
                state_next = ST_PEST;
            end
            ST_PEST:
            begin
                sum_next   = SUM_BITS'(prod_reg) + SUM_BITS'(sprod);
                state_next = ST_RESID;
            end
            ST_RESID:
            begin
                r_next       = r_sat;
                pending_next = 1'b1;
                phase_next   = phase_reg + inc_reg;
                state_next   = ST_ERRC;
            end
            ST_ERRC:
            begin
                t_next     = TERM_BITS'(rc_round >>> hct_pkg::REF_FRAC);
                state_next = ST_ERRS;
            end
            ST_ERRS:
            begin
                e_next     = CORR_BITS'(tm_round >>> hct_pkg::STEP_FRAC);
                t_next     = TERM_BITS'(rc_round >>> hct_pkg::REF_FRAC);
                state_next = ST_UPDC;
            end
            ST_UPDC:
            begin
                cw_next    = g_sat;
                e_next     = CORR_BITS'(tm_round >>> hct_pkg::STEP_FRAC);
                state_next = ST_UPDS;
            end
            ST_UPDS:
            begin
                sw_next    = g_sat;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            phase_reg   <= '0;
            cw_reg      <= '0;
            sw_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            cw_reg      <= cw_next;
            sw_reg      <= sw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rin_reg  <= rin_next;
        r_reg    <= r_next;
        s_reg    <= s_next;
        c_reg    <= c_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        t_reg    <= t_next;
        e_reg    <= e_next;
        inc_reg  <= inc_next;
        mu_reg   <= mu_next;
    end

endmodule

@@ hdl/harmonic_tone_canceller_unit.sv @@
// Top level of the harmonic tone canceller: register port, cell chain, output stage.
// Depends on hct_pkg, hct_cell and hct_sine_rom.
`timescale 1ns / 1ps

// Removes a hum series from a stream of signed audio samples. For each active harmonic
// k = 1..active_harmonics an oscillator at k * phase_increment gives a cosine and sine
// reference; the tone rebuilt from two adaptive gains is subtracted and both gains move
// by k * step_base times residual times reference (LMS). Gains and phases start at zero
// after reset. The harmonics form a chain of identical cells, each with its own
// oscillator, gains and sine ROM; the residual of cell k feeds cell k+1. Each cell
// works on one sample at a time (2 ROM reads, estimate, residual, 2 error products,
// 2 gain updates) and takes a new one only once done and its residual is taken.
// Registers are to be written over APB only while the block is idle; the block
// does not enforce this. Gains saturate to 32 bits and residuals to the sample range.

module harmonic_tone_canceller_unit #(
    parameter int MAX_HARMONICS   = hct_pkg::MAX_HARMONICS_DEF,
    parameter int SAMPLE_BITS     = hct_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = hct_pkg::TABLE_ADDR_BITS_DEF,
    localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [TDATA_BITS-1:0]             s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
    // output sample stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [TDATA_BITS-1:0]             m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hct_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [hct_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [hct_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int CNT_BITS = $clog2(MAX_HARMONICS + 1);
    localparam int IDX_BITS = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

    // ------------------------------------------------------------------
    // Register file: 0 active_harmonics, 1 phase_increment, 2 step_base
    // ------------------------------------------------------------------
    logic [hct_pkg::COUNT_REG_BITS-1:0] active_reg, active_next;
    logic [hct_pkg::PHASE_INC_BITS-1:0] phase_inc_reg, phase_inc_next;
    logic [hct_pkg::STEP_BITS-1:0]      step_reg, step_next;
    logic                               cfg_wr;
    logic [hct_pkg::REG_IDX_BITS-1:0]   reg_idx;
    hct_pkg::hct_cfg_t                  cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[hct_pkg::APB_ADDR_BITS-1:2];

    always_comb
    begin
        active_next    = active_reg;
        phase_inc_next = phase_inc_reg;
        step_next      = step_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                hct_pkg::REG_ACTIVE: active_next    = pwdata[hct_pkg::COUNT_REG_BITS-1:0];
                hct_pkg::REG_PHASE:  phase_inc_next = pwdata[hct_pkg::PHASE_INC_BITS-1:0];
                hct_pkg::REG_STEP:   step_next      = pwdata[hct_pkg::STEP_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            hct_pkg::REG_ACTIVE: prdata = hct_pkg::APB_DATA_BITS'(active_reg);
            hct_pkg::REG_PHASE:  prdata = hct_pkg::APB_DATA_BITS'(phase_inc_reg);
            hct_pkg::REG_STEP:   prdata = hct_pkg::APB_DATA_BITS'(step_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.phase_increment = phase_inc_reg;
    assign cfg.step_base       = step_reg;

    // Counts above the cell count behave as the full chain
    logic [CNT_BITS-1:0] eff_count;
    logic [IDX_BITS-1:0] last_idx;

    assign eff_count = (int'(active_reg) > MAX_HARMONICS) ? CNT_BITS'(MAX_HARMONICS)
                                                          : CNT_BITS'(active_reg);
    assign last_idx  = IDX_BITS'(eff_count - 1'b1);

    // ------------------------------------------------------------------
    // Cell chain. Cells beyond the active count see no transactions and
    // keep their gains and phases.
    // ------------------------------------------------------------------
    logic [MAX_HARMONICS-1:0]      cell_in_valid, cell_in_ready;
    logic [MAX_HARMONICS-1:0]      cell_out_valid, cell_out_ready;
    logic signed [SAMPLE_BITS-1:0] cell_in_sample  [MAX_HARMONICS];
    logic signed [SAMPLE_BITS-1:0] cell_out_sample [MAX_HARMONICS];
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          out_free;

    assign sample_in = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);

    for (genvar i = 0; i < MAX_HARMONICS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in_valid[i]  = s_axis_tvalid && (eff_count != '0);
            assign cell_in_sample[i] = sample_in;
        end
        else
        begin : g_link
            assign cell_in_valid[i]  = cell_out_valid[i-1] && (CNT_BITS'(i) < eff_count);
            assign cell_in_sample[i] = cell_out_sample[i-1];
        end

        // last active cell drains into the output stage
        if (i == MAX_HARMONICS - 1)
        begin : g_tail
            assign cell_out_ready[i] = (eff_count == CNT_BITS'(i + 1)) && out_free;
        end
        else
        begin : g_mid
            assign cell_out_ready[i] = (CNT_BITS'(i + 1) < eff_count) ? cell_in_ready[i+1] :
                                       ((eff_count == CNT_BITS'(i + 1)) && out_free);
        end

        hct_cell #(
            .SAMPLE_BITS     (SAMPLE_BITS),
            .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
            .MAX_HARMONICS   (MAX_HARMONICS),
            .HARM_NUM        (i + 1)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg),
            .in_valid   (cell_in_valid[i]),
            .in_ready   (cell_in_ready[i]),
            .in_sample  (cell_in_sample[i]),
            .out_valid  (cell_out_valid[i]),
            .out_ready  (cell_out_ready[i]),
            .out_sample (cell_out_sample[i])
        );
    end

    // With no harmonic active the sample goes straight to the output stage
    assign s_axis_tready = (eff_count == '0) ? out_free : cell_in_ready[0];

    // ------------------------------------------------------------------
    // Output register: takes a new residual while the previous one drains
    // ------------------------------------------------------------------
    logic                   src_valid;
    logic [SAMPLE_BITS-1:0] src_sample;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    assign src_valid  = (eff_count == '0) ? s_axis_tvalid : cell_out_valid[last_idx];
    assign src_sample = (eff_count == '0) ? unsigned'(sample_in)
                                          : unsigned'(cell_out_sample[last_idx]);
    assign out_free   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (src_valid && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = src_sample;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= hct_pkg::ACTIVE_RESET;
            phase_inc_reg <= hct_pkg::PHASE_RESET;
            step_reg      <= hct_pkg::STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_inc_reg <= phase_inc_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'(out_data_reg);

endmodule

@@ hdl/hct_checker.sv @@
// Port-level checks of the harmonic tone canceller, bound to the top level.
// Depends on hct_pkg and harmonic_tone_canceller_unit.
`timescale 1ns / 1ps

module hct_checker #(
    parameter int MAX_HARMONICS = hct_pkg::MAX_HARMONICS_DEF,
    parameter int SAMPLE_BITS   = hct_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [TDATA_BITS-1:0]             m_axis_tdata,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [hct_pkg::APB_ADDR_BITS-1:0] paddr,
    input logic [hct_pkg::APB_DATA_BITS-1:0] pwdata,
    input logic [hct_pkg::APB_DATA_BITS-1:0] prdata
);

    localparam int OUTST_BITS = $clog2(MAX_HARMONICS + 3) + 1;

    logic [OUTST_BITS-1:0] outst_reg, outst_next;
    logic                  in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        outst_next = outst_reg;
        if (in_xfer && !out_xfer)
        begin
            outst_next = outst_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // no result without an input transaction behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> outst_reg != '0)
        else $error("output transaction without pending input");

    // each cell and the output register hold one sample at most
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(outst_reg) <= MAX_HARMONICS + 1)
        else $error("more samples in flight than the chain can hold");

    // phase increment reads back as written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite &&
         paddr[hct_pkg::APB_ADDR_BITS-1:2] == hct_pkg::REG_PHASE) ##1
        (psel && !pwrite && paddr[hct_pkg::APB_ADDR_BITS-1:2] == hct_pkg::REG_PHASE)
        |-> prdata == hct_pkg::APB_DATA_BITS'($past(pwdata[hct_pkg::PHASE_INC_BITS-1:0])))
        else $error("phase increment readback mismatch");

endmodule

bind harmonic_tone_canceller_unit hct_checker #(
    .MAX_HARMONICS (MAX_HARMONICS),
    .SAMPLE_BITS   (SAMPLE_BITS)
) u_hct_checker (.*);
